### hdl/mi3_pkg.sv
package mi3_pkg;

    // fraction bits of the fixed point log2
    localparam int LOG_FRAC = 32;

    // result field
    localparam int OUT_W = 17;
    localparam logic [OUT_W-1:0] OUT_MAX = '1;

    // log base conversion factors, q0.32
    localparam logic [31:0] K_LN2     = 32'hB17217F8;
    localparam logic [31:0] K_LOG10_2 = 32'h4D104D42;

    // table shape
    localparam int N_SIDE = 3;
    localparam int N_CELL = N_SIDE * N_SIDE;

    // register codes
    localparam logic BASE_NATURAL = 1'b0;
    localparam logic BASE_DECIMAL = 1'b1;

endpackage

### hdl/mi3_log2.sv
module mi3_log2 import mi3_pkg::*; #(
    parameter int VW = 20,
    localparam int KW = $clog2(VW),
    localparam int LW = KW + LOG_FRAC
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [VW-1:0] i_val,
    output logic          o_valid,
    output logic [VW-1:0] o_val,
    output logic [LW-1:0] o_log
);

    logic [31:0]         r_x   [0:LOG_FRAC-1];
    logic [LOG_FRAC-1:0] r_f   [0:LOG_FRAC];
    logic [KW-1:0]       r_k   [0:LOG_FRAC];
    logic [VW-1:0]       r_v   [0:LOG_FRAC];
    logic                r_vld [0:LOG_FRAC];

    logic [KW-1:0] n_k;
    logic [31:0]   n_x0;

    // leading one position, then mantissa normalised to q1.31
    always_comb begin
        n_k = '0;
        for (int i = 0; i < VW; i++) begin
            if (i_val[i]) begin
                n_k = KW'(i);
            end
        end
        n_x0 = 32'({i_val, 31'b0} >> n_k);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_valid;
        end
        r_x[0] <= n_x0;
        r_f[0] <= '0;
        r_k[0] <= n_k;
        r_v[0] <= i_val;
    end

    // one fraction bit per stage by squaring
    for (genvar j = 1; j <= LOG_FRAC; j++) begin : g_sq
        logic [63:0] w_s;
        assign w_s = r_x[j-1] * r_x[j-1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else begin
                r_vld[j] <= r_vld[j-1];
            end
            r_f[j] <= {r_f[j-1][LOG_FRAC-2:0], w_s[63]};
            r_k[j] <= r_k[j-1];
            r_v[j] <= r_v[j-1];
        end

        if (j < LOG_FRAC) begin : g_x
            always_ff @(posedge i_clk) begin
                r_x[j] <= w_s[63] ? w_s[63:32] : w_s[62:31];
            end
        end
    end

    assign o_valid = r_vld[LOG_FRAC];
    assign o_val   = r_v[LOG_FRAC];
    assign o_log   = {r_k[LOG_FRAC], r_f[LOG_FRAC]};

endmodule

### hdl/mi3_div.sv
module mi3_div import mi3_pkg::*; #(
    parameter int NW = 80,
    parameter int DW = 20,
    parameter int QW = 37
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_valid,
    output logic [QW-1:0] o_quo
);

    logic [NW-1:0] r_n   [0:QW-2];
    logic [DW-1:0] r_d   [0:QW-2];
    logic [QW-1:0] r_q   [0:QW-1];
    logic          r_vld [0:QW-1];

    // restoring division, one quotient bit per stage, msb first
    for (genvar j = 0; j < QW; j++) begin : g_st
        localparam int B = QW - 1 - j;
        logic [NW-1:0] w_n;
        logic [DW-1:0] w_d;
        logic [QW-1:0] w_q;
        logic          w_v;
        logic [NW-1:0] w_ds;

        if (j == 0) begin : g_in
            assign w_n = i_num;
            assign w_d = i_den;
            assign w_q = '0;
            assign w_v = i_valid;
        end else begin : g_pr
            assign w_n = r_n[j-1];
            assign w_d = r_d[j-1];
            assign w_q = r_q[j-1];
            assign w_v = r_vld[j-1];
        end

        assign w_ds = NW'(w_d) << B;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else begin
                r_vld[j] <= w_v;
            end
            if (w_n >= w_ds) begin
                r_q[j] <= w_q | (QW'(1) << B);
            end else begin
                r_q[j] <= w_q;
            end
        end

        if (j < QW - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                r_n[j] <= (w_n >= w_ds) ? (w_n - w_ds) : w_n;
                r_d[j] <= w_d;
            end
        end
    end

    assign o_valid = r_vld[QW-1];
    assign o_quo   = r_q[QW-1];

endmodule

### hdl/mutual_information_3x3_top.sv
// mutual information of a 3x3 table of counts, one table per clock. a word is
// taken whenever start is high (busy is always low), and its result appears on
// o_mutual_info with o_valid high for exactly one cycle once the word has passed
// through every pipeline stage.
// the receiver cannot stall, so nothing is held back: every accepted word
// yields one result in order. most of the pipeline depth lies in the log2 lanes (one
// squaring stage per fraction bit) and the three entropy dividers (one
// quotient bit per stage). the result is unsigned q1.16 in nats, or in
// decimal digits when log_base_select (apb address 0, bit 0) is set; it is
// zero for an empty table or when rounding drives it negative, and saturates
// at the top of the field. write the base register only while no word is in
// flight.
module mutual_information_3x3_top import mi3_pkg::*; #(
    parameter int COUNT_WIDTH = 16,
    parameter int FRAC_BITS   = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [COUNT_WIDTH-1:0] i_count_00,
    input  logic [COUNT_WIDTH-1:0] i_count_01,
    input  logic [COUNT_WIDTH-1:0] i_count_02,
    input  logic [COUNT_WIDTH-1:0] i_count_10,
    input  logic [COUNT_WIDTH-1:0] i_count_11,
    input  logic [COUNT_WIDTH-1:0] i_count_12,
    input  logic [COUNT_WIDTH-1:0] i_count_20,
    input  logic [COUNT_WIDTH-1:0] i_count_21,
    input  logic [COUNT_WIDTH-1:0] i_count_22,
    output logic                   o_valid,
    output logic [OUT_W-1:0]       o_mutual_info,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [2:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    // widths: sums of nine counts need four more bits
    localparam int TW  = COUNT_WIDTH + 4;
    localparam int KW  = $clog2(TW);
    localparam int LW  = KW + LOG_FRAC;
    localparam int PLW = TW + 32;
    localparam int PHW = TW + KW;
    localparam int TRW = TW + LW;
    localparam int SW  = TRW + 4;
    localparam int QW  = LW;
    localparam int MW  = QW + 1;
    localparam int MHW = MW - 32;
    localparam int PW  = MW + 32;
    localparam int SH  = 64 - FRAC_BITS;
    localparam int NV  = N_CELL + 2 * N_SIDE + 1;
    localparam int NT  = NV - 1;
    localparam int ITOT = NV - 1;
    localparam int LAT = 43 + QW;

    // ---------------- configuration ----------------
    logic r_log_base_select;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_log_base_select <= BASE_NATURAL;
        end else if (psel && penable && pwrite && pready && (paddr == 3'd0)) begin
            r_log_base_select <= pwdata[0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == 3'd0) ? {31'b0, r_log_base_select} : 32'b0;
    assign busy   = 1'b0;

    // ---------------- input register ----------------
    logic [COUNT_WIDTH-1:0] w_in [0:N_CELL-1];
    logic [COUNT_WIDTH-1:0] r_c  [0:N_CELL-1];
    logic                   r_s0_vld;

    assign w_in[0] = i_count_00;
    assign w_in[1] = i_count_01;
    assign w_in[2] = i_count_02;
    assign w_in[3] = i_count_10;
    assign w_in[4] = i_count_11;
    assign w_in[5] = i_count_12;
    assign w_in[6] = i_count_20;
    assign w_in[7] = i_count_21;
    assign w_in[8] = i_count_22;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
        end else begin
            r_s0_vld <= start && !busy;
        end
        for (int i = 0; i < N_CELL; i++) begin
            r_c[i] <= w_in[i];
        end
    end

    // ---------------- marginals and total ----------------
    // lanes: cells 0..8, rows 9..11, columns 12..14, total 15
    logic [TW-1:0] r_v1 [0:NV-1];
    logic          r_s1_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= r_s0_vld;
        end
        for (int i = 0; i < N_CELL; i++) begin
            r_v1[i] <= TW'(r_c[i]);
        end
        for (int i = 0; i < N_SIDE; i++) begin
            r_v1[N_CELL+i] <= TW'(r_c[3*i]) + TW'(r_c[3*i+1]) + TW'(r_c[3*i+2]);
            r_v1[N_CELL+N_SIDE+i] <= TW'(r_c[i]) + TW'(r_c[i+3]) + TW'(r_c[i+6]);
        end
        r_v1[ITOT] <= TW'(r_c[0]) + TW'(r_c[1]) + TW'(r_c[2]) + TW'(r_c[3])
                    + TW'(r_c[4]) + TW'(r_c[5]) + TW'(r_c[6]) + TW'(r_c[7])
                    + TW'(r_c[8]);
    end

    // ---------------- log2 lanes ----------------
    logic [LW-1:0] w_lg [0:NV-1];
    logic [TW-1:0] w_lv [0:NV-1];
    logic          w_lg_vld;

    for (genvar i = 0; i < NV; i++) begin : g_log
        if (i == 0) begin : g_first
            mi3_log2 #(.VW(TW)) u_log (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_valid (r_s1_vld),
                .i_val   (r_v1[i]),
                .o_valid (w_lg_vld),
                .o_val   (w_lv[i]),
                .o_log   (w_lg[i])
            );
        end else begin : g_rest
            mi3_log2 #(.VW(TW)) u_log (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_valid (r_s1_vld),
                .i_val   (r_v1[i]),
                .o_valid (),
                .o_val   (w_lv[i]),
                .o_log   (w_lg[i])
            );
        end
    end

    // ---------------- information per term: log N - log v ----------------
    logic [LW-1:0] r_q  [0:NT-1];
    logic [TW-1:0] r_qv [0:NT-1];
    logic [TW-1:0] r_qn;
    logic          r_sq_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_vld <= 1'b0;
        end else begin
            r_sq_vld <= w_lg_vld;
        end
        for (int i = 0; i < NT; i++) begin
            r_q[i]  <= (w_lg[i] < w_lg[ITOT]) ? (w_lg[ITOT] - w_lg[i]) : '0;
            r_qv[i] <= w_lv[i];
        end
        r_qn <= w_lv[ITOT];
    end

    // ---------------- v * q, split at bit 32 of q ----------------
    logic [PLW-1:0] r_pl [0:NT-1];
    logic [PHW-1:0] r_ph [0:NT-1];
    logic [TW-1:0]  r_pn;
    logic           r_p1_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld <= 1'b0;
        end else begin
            r_p1_vld <= r_sq_vld;
        end
        for (int i = 0; i < NT; i++) begin
            r_pl[i] <= PLW'(r_qv[i]) * PLW'(r_q[i][31:0]);
            r_ph[i] <= PHW'(r_qv[i]) * PHW'(r_q[i][LW-1:32]);
        end
        r_pn <= r_qn;
    end

    logic [TRW-1:0] r_t [0:NT-1];
    logic [TW-1:0]  r_tn;
    logic           r_p2_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_vld <= 1'b0;
        end else begin
            r_p2_vld <= r_p1_vld;
        end
        for (int i = 0; i < NT; i++) begin
            r_t[i] <= TRW'(r_pl[i]) + (TRW'(r_ph[i]) << 32);
        end
        r_tn <= r_pn;
    end

    // ---------------- entropy sums, two levels ----------------
    logic [SW-1:0] r_ar;
    logic [SW-1:0] r_ac;
    logic [SW-1:0] r_ag [0:N_SIDE-1];
    logic [TW-1:0] r_an;
    logic          r_p3_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p3_vld <= 1'b0;
        end else begin
            r_p3_vld <= r_p2_vld;
        end
        r_ar <= SW'(r_t[N_CELL]) + SW'(r_t[N_CELL+1]) + SW'(r_t[N_CELL+2]);
        r_ac <= SW'(r_t[N_CELL+3]) + SW'(r_t[N_CELL+4]) + SW'(r_t[N_CELL+5]);
        for (int i = 0; i < N_SIDE; i++) begin
            r_ag[i] <= SW'(r_t[3*i]) + SW'(r_t[3*i+1]) + SW'(r_t[3*i+2]);
        end
        r_an <= r_tn;
    end

    logic [SW-1:0] r_nr;
    logic [SW-1:0] r_nc;
    logic [SW-1:0] r_nj;
    logic [TW-1:0] r_den;
    logic          r_p4_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p4_vld <= 1'b0;
        end else begin
            r_p4_vld <= r_p3_vld;
        end
        r_nr  <= r_ar;
        r_nc  <= r_ac;
        r_nj  <= r_ag[0] + r_ag[1] + r_ag[2];
        // empty table: sums are zero, a unit divisor keeps the quotients zero
        r_den <= (r_an == '0) ? TW'(1) : r_an;
    end

    // ---------------- entropies: divide by the total ----------------
    logic [QW-1:0] w_hr;
    logic [QW-1:0] w_hc;
    logic [QW-1:0] w_hj;
    logic          w_h_vld;

    mi3_div #(.NW(SW), .DW(TW), .QW(QW)) u_div_r (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_p4_vld),
        .i_num   (r_nr),
        .i_den   (r_den),
        .o_valid (w_h_vld),
        .o_quo   (w_hr)
    );

    mi3_div #(.NW(SW), .DW(TW), .QW(QW)) u_div_c (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_p4_vld),
        .i_num   (r_nc),
        .i_den   (r_den),
        .o_valid (),
        .o_quo   (w_hc)
    );

    mi3_div #(.NW(SW), .DW(TW), .QW(QW)) u_div_j (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_p4_vld),
        .i_num   (r_nj),
        .i_den   (r_den),
        .o_valid (),
        .o_quo   (w_hj)
    );

    // ---------------- h(rows) + h(cols) - h(joint), clamped at zero ----------------
    logic [MW-1:0] w_hsum;
    logic [MW-1:0] r_mpos;
    logic          r_m_vld;

    assign w_hsum = MW'(w_hr) + MW'(w_hc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
        end else begin
            r_m_vld <= w_h_vld;
        end
        r_mpos <= (w_hsum > MW'(w_hj)) ? (w_hsum - MW'(w_hj)) : '0;
    end

    // ---------------- base conversion, split at bit 32 ----------------
    logic [31:0]      w_kf;
    logic [63:0]      r_kl;
    logic [MHW+31:0]  r_kh;
    logic             r_k_vld;

    assign w_kf = (r_log_base_select == BASE_DECIMAL) ? K_LOG10_2 : K_LN2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_vld <= 1'b0;
        end else begin
            r_k_vld <= r_m_vld;
        end
        r_kl <= 64'(r_mpos[31:0]) * 64'(w_kf);
        r_kh <= (MHW+32)'(r_mpos[MW-1:32]) * (MHW+32)'(w_kf);
    end

    // ---------------- scale to the output and saturate ----------------
    logic [PW-1:0] w_prod;
    logic [PW-1:0] w_scaled;

    assign w_prod   = PW'(r_kl) + (PW'(r_kh) << 32);
    assign w_scaled = w_prod >> SH;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_k_vld;
        end
        o_mutual_info <= (w_scaled > PW'(OUT_MAX)) ? OUT_MAX : w_scaled[OUT_W-1:0];
    end

    // ---------------- checks ----------------
    a_latency_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_valid)
        else $error("accepted word gave no result at the expected cycle");

    a_latency_rev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LAT))
        else $error("result without a matching accepted word");

    a_nonzero_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_mutual_info != '0)) |-> ($past(r_mpos, 2) != '0))
        else $error("nonzero result from a clamped difference");

endmodule
